[rtl/core/srt_pkg.sv]
// Shared types, constants and saturating arithmetic helpers for the
// scaled rigid transform point unit. No dependencies.
`default_nettype none

package srt_pkg;

    // Default coordinate width and the widest coordinate the helpers support.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_WIDTH_MAX = 64;

    // Fraction bits of the quaternion (Q2.14) and of the scale (Q8.8).
    localparam int QUAT_FRAC  = 14;
    localparam int SCALE_FRAC = 8;

    // Working width for exact sums and products before saturation.
    localparam int WIDE_W = COORD_WIDTH_MAX + 20;

    // Function selector codes carried in tuser.
    localparam logic FUNC_FORWARD = 1'b0;
    localparam logic FUNC_INVERSE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_QUAT    = 3'd0;
    localparam logic [2:0] REG_POS_X   = 3'd1;
    localparam logic [2:0] REG_POS_Y   = 3'd2;
    localparam logic [2:0] REG_POS_Z   = 3'd3;
    localparam logic [2:0] REG_SCALE_X = 3'd4;
    localparam logic [2:0] REG_SCALE_Y = 3'd5;
    localparam logic [2:0] REG_SCALE_Z = 3'd6;

    // Register reset values.
    localparam logic [63:0] QUAT_RESET  = 64'd16384;
    localparam logic [15:0] SCALE_RESET = 16'd256;

    // Control that travels with each word through the pipeline.
    typedef struct packed {
        logic valid;
        logic func;
        logic zs;
        logic ov;
    } srt_ctl_t;

    // Clamp a wide signed value to a cw-bit signed range; the top bit flags a clamp.
    function automatic logic [WIDE_W:0] sat_wide(input logic signed [WIDE_W-1:0] x,
                                                 input int unsigned cw);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (WIDE_W'(1) << (cw - 1)) - WIDE_W'(1);
        lo = ~hi;
        if (x > hi) begin
            return {1'b1, hi};
        end else if (x < lo) begin
            return {1'b1, lo};
        end
        return {1'b0, x};
    endfunction

    // Round half up by sh bits, then clamp to cw bits.
    function automatic logic [WIDE_W:0] rnd_wide(input logic signed [WIDE_W-1:0] x,
                                                 input int unsigned sh,
                                                 input int unsigned cw);
        logic signed [WIDE_W-1:0] t;
        t = x + (WIDE_W'(1) << (sh - 1));
        t = t >>> sh;
        return sat_wide(t, cw);
    endfunction

endpackage

`default_nettype wire

[rtl/core/srt_prep.sv]
// Front stages: per-axis scaling (forward) or position subtraction (inverse).
// Depends on srt_pkg.
`default_nettype none

module srt_prep
    import srt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  srt_ctl_t               ctl_i,
    input  logic [COORD_WIDTH-1:0] pt_i [3],
    input  logic [2:0][31:0]       pos_i,
    input  logic [2:0][15:0]       scale_i,
    output srt_ctl_t               ctl_o,
    output logic [COORD_WIDTH-1:0] v_o [3]
);

    localparam int CW  = COORD_WIDTH;
    localparam int SPW = CW + 16;

    logic signed [SPW-1:0]    prod [3];
    logic signed [WIDE_W-1:0] diff [3];
    logic signed [WIDE_W-1:0] wide_a_next [3];
    logic signed [WIDE_W-1:0] wide_a_reg [3];
    srt_ctl_t                 ctl_a_reg;
    logic [WIDE_W:0]          fit_b [3];
    logic [CW-1:0]            v_b_next [3];
    logic [CW-1:0]            v_b_reg [3];
    srt_ctl_t                 ctl_b_next;
    srt_ctl_t                 ctl_b_reg;

    // Stage A: exact scale product or exact difference to the position.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = $signed(pt_i[i]) * $signed(scale_i[i]);
            diff[i] = WIDE_W'($signed(pt_i[i])) - WIDE_W'($signed(pos_i[i]));
            wide_a_next[i] = (ctl_i.func == FUNC_INVERSE) ? diff[i] : WIDE_W'(prod[i]);
        end
    end

    // Stage B: round the scale product, or just saturate the difference.
    always_comb begin
        ctl_b_next = ctl_a_reg;
        for (int i = 0; i < 3; i++) begin
            fit_b[i] = (ctl_a_reg.func == FUNC_INVERSE) ?
                       sat_wide(wide_a_reg[i], CW) :
                       rnd_wide(wide_a_reg[i], SCALE_FRAC, CW);
            v_b_next[i] = fit_b[i][CW-1:0];
        end
        ctl_b_next.ov = ctl_a_reg.ov | fit_b[0][WIDE_W] | fit_b[1][WIDE_W] |
                        fit_b[2][WIDE_W];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= ctl_i;
            ctl_b_reg <= ctl_b_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            wide_a_reg <= wide_a_next;
            v_b_reg    <= v_b_next;
        end
    end

    assign ctl_o = ctl_b_reg;
    assign v_o   = v_b_reg;

endmodule

`default_nettype wire

[rtl/core/srt_rotate.sv]
// Quaternion rotation v + 2w(q x v) + 2(q x (q x v)) in five stages, followed by
// a stage for the forward position add. Depends on srt_pkg.
`default_nettype none

module srt_rotate
    import srt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  srt_ctl_t               ctl_i,
    input  logic [COORD_WIDTH-1:0] v_i [3],
    input  logic [63:0]            quat_i,
    input  logic [2:0][31:0]       pos_i,
    output srt_ctl_t               ctl_o,
    output logic [COORD_WIDTH-1:0] r_o [3]
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = CW + 17;

    // Quaternion component k (x, y, z, then w), conjugated for the inverse.
    function automatic logic signed [16:0] qcomp(input logic [63:0] q, input int unsigned k,
                                                 input logic func);
        logic signed [15:0] raw;
        logic signed [16:0] c;
        case (k)
            0: raw = q[63:48];
            1: raw = q[47:32];
            2: raw = q[31:16];
            default: raw = q[15:0];
        endcase
        c = 17'(raw);
        if (func == FUNC_INVERSE && k != 3) begin
            c = -c;
        end
        return c;
    endfunction

    logic signed [16:0] qc_c [3];
    logic signed [16:0] qc_e [3];
    logic signed [16:0] qw_e;

    logic signed [PW-1:0] m1_next [3];
    logic signed [PW-1:0] m2_next [3];
    logic signed [PW-1:0] m1_reg [3];
    logic signed [PW-1:0] m2_reg [3];
    logic [CW-1:0]        v_c_reg [3];
    srt_ctl_t             ctl_c_reg;

    logic [WIDE_W:0]      c_fit [3];
    logic [CW-1:0]        c_d_reg [3];
    logic [CW-1:0]        v_d_reg [3];
    srt_ctl_t             ctl_d_next;
    srt_ctl_t             ctl_d_reg;

    logic signed [PW-1:0] n1_next [3];
    logic signed [PW-1:0] n2_next [3];
    logic signed [PW-1:0] n3_next [3];
    logic signed [PW-1:0] n1_reg [3];
    logic signed [PW-1:0] n2_reg [3];
    logic signed [PW-1:0] n3_reg [3];
    logic [CW-1:0]        v_e_reg [3];
    srt_ctl_t             ctl_e_reg;

    logic [WIDE_W:0]      d_fit [3];
    logic [WIDE_W:0]      e_fit [3];
    logic [CW-1:0]        d_f_reg [3];
    logic [CW-1:0]        e_f_reg [3];
    logic [CW-1:0]        v_f_reg [3];
    srt_ctl_t             ctl_f_next;
    srt_ctl_t             ctl_f_reg;

    logic [WIDE_W:0]      o_fit [3];
    logic [CW-1:0]        o_g_reg [3];
    srt_ctl_t             ctl_g_next;
    srt_ctl_t             ctl_g_reg;

    logic [WIDE_W:0]      h_fit [3];
    logic [CW-1:0]        r_h_next [3];
    logic [CW-1:0]        r_h_reg [3];
    srt_ctl_t             ctl_h_next;
    srt_ctl_t             ctl_h_reg;

    // Quaternion components seen by the two multiply stages.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qc_c[k] = qcomp(quat_i, k, ctl_i.func);
            qc_e[k] = qcomp(quat_i, k, ctl_d_reg.func);
        end
        qw_e = qcomp(quat_i, 3, ctl_d_reg.func);
    end

    // Per-axis cross product terms; each axis uses the two other axes.
    for (genvar i = 0; i < 3; i++) begin : g_axis
        localparam int A = (i + 1) % 3;
        localparam int B = (i + 2) % 3;

        // Stage C: products of the first cross product.
        assign m1_next[i] = $signed(v_i[B]) * qc_c[A];
        assign m2_next[i] = $signed(v_i[A]) * qc_c[B];

        // Stage D: first cross product, rounded to the coordinate format.
        assign c_fit[i] = rnd_wide(WIDE_W'(m1_reg[i]) - WIDE_W'(m2_reg[i]), QUAT_FRAC, CW);

        // Stage E: products of the second cross product and of the w term.
        assign n1_next[i] = $signed(c_d_reg[B]) * qc_e[A];
        assign n2_next[i] = $signed(c_d_reg[A]) * qc_e[B];
        assign n3_next[i] = $signed(c_d_reg[i]) * qw_e;

        // Stage F: doubled terms, the doubling folded into the rounding shift.
        assign d_fit[i] = rnd_wide(WIDE_W'(n1_reg[i]) - WIDE_W'(n2_reg[i]),
                                   QUAT_FRAC - 1, CW);
        assign e_fit[i] = rnd_wide(WIDE_W'(n3_reg[i]), QUAT_FRAC - 1, CW);

        // Stage G: exact three-term sum, then saturate.
        assign o_fit[i] = sat_wide(WIDE_W'($signed(v_f_reg[i])) +
                                   WIDE_W'($signed(e_f_reg[i])) +
                                   WIDE_W'($signed(d_f_reg[i])), CW);

        // Stage H: forward adds the position.
        assign h_fit[i] = sat_wide(WIDE_W'($signed(o_g_reg[i])) +
                                   WIDE_W'($signed(pos_i[i])), CW);
        assign r_h_next[i] = (ctl_g_reg.func == FUNC_INVERSE) ? o_g_reg[i] :
                             h_fit[i][CW-1:0];
    end

    // Overflow flags collected at each saturating stage.
    always_comb begin
        ctl_d_next    = ctl_c_reg;
        ctl_d_next.ov = ctl_c_reg.ov | c_fit[0][WIDE_W] | c_fit[1][WIDE_W] |
                        c_fit[2][WIDE_W];
        ctl_f_next    = ctl_e_reg;
        ctl_f_next.ov = ctl_e_reg.ov | d_fit[0][WIDE_W] | d_fit[1][WIDE_W] |
                        d_fit[2][WIDE_W] | e_fit[0][WIDE_W] | e_fit[1][WIDE_W] |
                        e_fit[2][WIDE_W];
        ctl_g_next    = ctl_f_reg;
        ctl_g_next.ov = ctl_f_reg.ov | o_fit[0][WIDE_W] | o_fit[1][WIDE_W] |
                        o_fit[2][WIDE_W];
        ctl_h_next    = ctl_g_reg;
        if (ctl_g_reg.func == FUNC_FORWARD) begin
            ctl_h_next.ov = ctl_g_reg.ov | h_fit[0][WIDE_W] | h_fit[1][WIDE_W] |
                            h_fit[2][WIDE_W];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
            ctl_f_reg <= '0;
            ctl_g_reg <= '0;
            ctl_h_reg <= '0;
        end else if (en) begin
            ctl_c_reg <= ctl_i;
            ctl_d_reg <= ctl_d_next;
            ctl_e_reg <= ctl_d_reg;
            ctl_f_reg <= ctl_f_next;
            ctl_g_reg <= ctl_g_next;
            ctl_h_reg <= ctl_h_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m1_reg[i]  <= m1_next[i];
                m2_reg[i]  <= m2_next[i];
                v_c_reg[i] <= v_i[i];
                c_d_reg[i] <= c_fit[i][CW-1:0];
                v_d_reg[i] <= v_c_reg[i];
                n1_reg[i]  <= n1_next[i];
                n2_reg[i]  <= n2_next[i];
                n3_reg[i]  <= n3_next[i];
                v_e_reg[i] <= v_d_reg[i];
                d_f_reg[i] <= d_fit[i][CW-1:0];
                e_f_reg[i] <= e_fit[i][CW-1:0];
                v_f_reg[i] <= v_e_reg[i];
                o_g_reg[i] <= o_fit[i][CW-1:0];
                r_h_reg[i] <= r_h_next[i];
            end
        end
    end

    assign ctl_o = ctl_h_reg;
    assign r_o   = r_h_reg;

endmodule

`default_nettype wire

[rtl/core/srt_divide.sv]
// Pipelined restoring divider by the Q8.8 scale, one quotient bit per stage and
// three lanes; forward words pass through. Depends on srt_pkg.
`default_nettype none

module srt_divide
    import srt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  srt_ctl_t               ctl_i,
    input  logic [COORD_WIDTH-1:0] r_i [3],
    input  logic [2:0][15:0]       scale_i,
    output srt_ctl_t               ctl_o,
    output logic [COORD_WIDTH-1:0] res_o [3]
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = CW + SCALE_FRAC;
    localparam int NS = NW;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic [15:0]    dmag [3];
    logic [CW-1:0]  mag [3];
    logic [CW-1:0]  pass_val [3];
    logic [2:0]     dz;
    logic [2:0]     ovl;

    logic [NW-1:0]  work_next [NS+1][3];
    logic [14:0]    rem_next [NS+1][3];
    logic [2:0]     neg_pre;
    logic [2:0]     div_pre;
    srt_ctl_t       ctl_pre;

    logic [NW-1:0]  work_reg [NS+1][3];
    logic [14:0]    rem_reg [NS+1][3];
    logic [2:0]     neg_reg [NS+1];
    logic [2:0]     div_reg [NS+1];
    srt_ctl_t       ctl_reg [NS+1];

    logic [15:0]    t_w [NS][3];
    logic           ge_w [NS][3];

    logic signed [WIDE_W-1:0] quo [3];
    logic [WIDE_W:0]          q_fit [3];
    logic [CW-1:0]            fin_next [3];
    logic [CW-1:0]            fin_reg [3];
    srt_ctl_t                 ctl_fin_next;
    srt_ctl_t                 ctl_fin_reg;

    // Pre stage: magnitudes, signs and the zero scale cases.
    always_comb begin
        ctl_pre = ctl_i;
        for (int l = 0; l < 3; l++) begin
            dmag[l]     = scale_i[l][15] ? 16'(-$signed(scale_i[l])) : scale_i[l];
            dz[l]       = (scale_i[l] == '0);
            div_pre[l]  = (ctl_i.func == FUNC_INVERSE) && !dz[l];
            neg_pre[l]  = r_i[l][CW-1] ^ scale_i[l][15];
            mag[l]      = r_i[l][CW-1] ? CW'(-$signed(r_i[l])) : r_i[l];
            ovl[l]      = (ctl_i.func == FUNC_INVERSE) && dz[l] && (r_i[l] != '0);
            pass_val[l] = r_i[l];
            if ((ctl_i.func == FUNC_INVERSE) && dz[l] && (r_i[l] != '0)) begin
                pass_val[l] = r_i[l][CW-1] ? CMIN : CMAX;
            end
            work_next[0][l] = div_pre[l] ? {mag[l], {SCALE_FRAC{1'b0}}} :
                                           {{SCALE_FRAC{1'b0}}, pass_val[l]};
            rem_next[0][l]  = '0;
        end
        ctl_pre.zs = (ctl_i.func == FUNC_INVERSE) && (dz != '0);
        ctl_pre.ov = ctl_i.ov | (ovl != '0);
    end

    // Quotient stages: one compare and subtract per lane and stage.
    for (genvar s = 0; s < NS; s++) begin : g_stage
        for (genvar l = 0; l < 3; l++) begin : g_lane
            assign t_w[s][l]  = {rem_reg[s][l], work_reg[s][l][NW-1]};
            assign ge_w[s][l] = (t_w[s][l] >= dmag[l]);
            assign work_next[s+1][l] = div_reg[s][l] ?
                                       {work_reg[s][l][NW-2:0], ge_w[s][l]} :
                                       work_reg[s][l];
            assign rem_next[s+1][l]  = !div_reg[s][l] ? rem_reg[s][l] :
                                       ge_w[s][l] ? 15'(t_w[s][l] - dmag[l]) :
                                       t_w[s][l][14:0];
        end
    end

    // Final stage: apply the sign and saturate the quotient.
    always_comb begin
        ctl_fin_next = ctl_reg[NS];
        for (int l = 0; l < 3; l++) begin
            quo[l] = neg_reg[NS][l] ? -WIDE_W'(work_reg[NS][l]) : WIDE_W'(work_reg[NS][l]);
            q_fit[l] = sat_wide(quo[l], CW);
            fin_next[l] = div_reg[NS][l] ? q_fit[l][CW-1:0] : work_reg[NS][l][CW-1:0];
            if (div_reg[NS][l] && q_fit[l][WIDE_W]) begin
                ctl_fin_next.ov = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NS; s++) begin
                ctl_reg[s] <= '0;
            end
            ctl_fin_reg <= '0;
        end else if (en) begin
            ctl_reg[0] <= ctl_pre;
            for (int s = 1; s <= NS; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            ctl_fin_reg <= ctl_fin_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= neg_pre;
            div_reg[0] <= div_pre;
            for (int s = 1; s <= NS; s++) begin
                neg_reg[s] <= neg_reg[s-1];
                div_reg[s] <= div_reg[s-1];
            end
            for (int s = 0; s <= NS; s++) begin
                work_reg[s] <= work_next[s];
                rem_reg[s]  <= rem_next[s];
            end
            fin_reg <= fin_next;
        end
    end

    assign ctl_o = ctl_fin_reg;
    assign res_o = fin_reg;

endmodule

`default_nettype wire

[rtl/core/scaled_rigid_transform_point_unit.sv]
// Top level: configuration registers, stream handshake and output register.
// Depends on srt_pkg, srt_prep, srt_rotate and srt_divide.
//
// Transforms one 3D point per word: forward scales, rotates by the quaternion
// and adds the position; inverse subtracts the position, rotates by the conjugate
// and divides by the scale. The unit takes one word per clock while the output
// is not stalled. The divider resolves one quotient bit per stage. Every word
// travels the full pipeline. A stall at the output holds the whole pipeline.
// The user must write registers only while the pipeline is empty; the block
// itself does not enforce this.
`default_nettype none

module scaled_rigid_transform_point_unit
    import srt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int SD_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    // Input stream.
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [SD_W-1:0] s_tdata,   // point_x, point_y, point_z, zero fill
    input  logic            s_tuser,   // func
    // Result stream.
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [SD_W-1:0] m_tdata,   // result_x, result_y, result_z, zero fill
    output logic [1:0]      m_tuser,   // zero_scale, overflowed
    // Configuration port.
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready
);

    localparam int CW = COORD_WIDTH;

    logic [63:0]       quat_reg;
    logic [2:0][31:0]  pos_reg;
    logic [2:0][15:0]  scale_reg;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    logic              en;
    srt_ctl_t          ctl_in;
    logic [CW-1:0]     pt [3];
    srt_ctl_t          ctl_prep;
    logic [CW-1:0]     v_prep [3];
    srt_ctl_t          ctl_rot;
    logic [CW-1:0]     r_rot [3];
    srt_ctl_t          ctl_div;
    logic [CW-1:0]     res_div [3];

    logic              m_tvalid_reg;
    logic [3*CW-1:0]   m_data_reg;
    logic [1:0]        m_user_reg;

    // Configuration writes.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg  <= QUAT_RESET;
            pos_reg   <= '0;
            scale_reg <= {3{SCALE_RESET}};
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_QUAT:    quat_reg     <= pwdata;
                REG_POS_X:   pos_reg[0]   <= pwdata[31:0];
                REG_POS_Y:   pos_reg[1]   <= pwdata[31:0];
                REG_POS_Z:   pos_reg[2]   <= pwdata[31:0];
                REG_SCALE_X: scale_reg[0] <= pwdata[15:0];
                REG_SCALE_Y: scale_reg[1] <= pwdata[15:0];
                REG_SCALE_Z: scale_reg[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        case (cfg_idx)
            REG_QUAT:    prdata = quat_reg;
            REG_POS_X:   prdata = {32'd0, pos_reg[0]};
            REG_POS_Y:   prdata = {32'd0, pos_reg[1]};
            REG_POS_Z:   prdata = {32'd0, pos_reg[2]};
            REG_SCALE_X: prdata = {48'd0, scale_reg[0]};
            REG_SCALE_Y: prdata = {48'd0, scale_reg[1]};
            REG_SCALE_Z: prdata = {48'd0, scale_reg[2]};
            default:     prdata = '0;
        endcase
    end

    // The pipeline advances whenever the output register can take a word.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Unpack the input word.
    always_comb begin
        ctl_in       = '0;
        ctl_in.valid = s_tvalid;
        ctl_in.func  = s_tuser;
        for (int i = 0; i < 3; i++) begin
            pt[i] = s_tdata[i*CW +: CW];
        end
    end

    srt_prep #(
        .COORD_WIDTH(CW)
    ) u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (ctl_in),
        .pt_i    (pt),
        .pos_i   (pos_reg),
        .scale_i (scale_reg),
        .ctl_o   (ctl_prep),
        .v_o     (v_prep)
    );

    srt_rotate #(
        .COORD_WIDTH(CW)
    ) u_rotate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (ctl_prep),
        .v_i     (v_prep),
        .quat_i  (quat_reg),
        .pos_i   (pos_reg),
        .ctl_o   (ctl_rot),
        .r_o     (r_rot)
    );

    srt_divide #(
        .COORD_WIDTH(CW)
    ) u_divide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (ctl_rot),
        .r_i     (r_rot),
        .scale_i (scale_reg),
        .ctl_o   (ctl_div),
        .res_o   (res_div)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ctl_div.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {res_div[2], res_div[1], res_div[0]};
            m_user_reg <= {ctl_div.ov, ctl_div.zs};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = SD_W'(m_data_reg);
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

[tb/scaled_rigid_transform_point_unit_tb.sv]
// Self-checking testbench for the scaled rigid transform point unit.
// Depends on srt_pkg and the unit's RTL; holds its own bit-exact predictor.
`default_nettype none

module scaled_rigid_transform_point_unit_tb
    import srt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] acc_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        zs;
        logic        ov;
    } point_result_t;

    localparam acc_t COORD_MAX = 128'sd2147483647;
    localparam acc_t COORD_MIN = -COORD_MAX - 1;
    localparam int   TIMEOUT_CYCLES = 400000;
    localparam int   DRAIN_CYCLES = 60;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    // Shadow copy of the configuration registers.
    logic [63:0]        quat_reg = QUAT_RESET;
    logic signed [31:0] pos_reg [3] = '{0, 0, 0};
    logic signed [15:0] scale_reg [3] = '{16'sd256, 16'sd256, 16'sd256};

    point_result_t pending_results[$];
    int  errors = 0;
    int  cycles = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  inverse_words = 0;
    int  zero_scale_seen = 0;
    int  overflow_seen = 0;
    bit  gaps_on = 1'b1;

    scaled_rigid_transform_point_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Clamp a wide value to the coordinate range.
    function automatic acc_t clamp(input acc_t v, inout logic ov);
        if (v > COORD_MAX) begin
            ov = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            ov = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // Round half up by sh bits, then clamp.
    function automatic acc_t round_clamp(input acc_t v, input int sh, inout logic ov);
        acc_t one;
        one = 1;
        return clamp((v + (one <<< (sh - 1))) >>> sh, ov);
    endfunction

    // Expected result of one point under the current register settings.
    function automatic point_result_t predict_point(input logic func,
                                                    input logic [95:0] pts);
        acc_t p [3], v [3], c [3], d [3], e [3], r [3], q [3], sc [3];
        acc_t qw;
        logic ov, zs;
        int a, b;
        point_result_t res;
        ov = 1'b0;
        zs = 1'b0;
        qw = acc_t'(signed'(quat_reg[15:0]));
        q[2] = acc_t'(signed'(quat_reg[31:16]));
        q[1] = acc_t'(signed'(quat_reg[47:32]));
        q[0] = acc_t'(signed'(quat_reg[63:48]));
        for (int i = 0; i < 3; i++) begin
            p[i] = acc_t'(signed'(pts[32*i +: 32]));
            sc[i] = acc_t'(scale_reg[i]);
        end
        // Forward scales first; inverse removes the position and conjugates.
        for (int i = 0; i < 3; i++) begin
            if (func == FUNC_FORWARD) begin
                v[i] = round_clamp(p[i] * sc[i], SCALE_FRAC, ov);
            end else begin
                v[i] = clamp(p[i] - acc_t'(pos_reg[i]), ov);
                q[i] = -q[i];
            end
        end
        // Rotation as v + 2w(q x v) + 2(q x (q x v)).
        for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            c[i] = round_clamp(v[b] * q[a] - v[a] * q[b], QUAT_FRAC, ov);
        end
        for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            d[i] = round_clamp(c[b] * q[a] - c[a] * q[b], QUAT_FRAC - 1, ov);
            e[i] = round_clamp(c[i] * qw, QUAT_FRAC - 1, ov);
        end
        for (int i = 0; i < 3; i++) begin
            r[i] = clamp(v[i] + e[i] + d[i], ov);
            if (func == FUNC_FORWARD) begin
                r[i] = clamp(r[i] + acc_t'(pos_reg[i]), ov);
            end else if (sc[i] == 0) begin
                // A zero scale saturates by the sign of the dividend.
                zs = 1'b1;
                if (r[i] > 0) begin
                    r[i] = COORD_MAX;
                    ov = 1'b1;
                end else if (r[i] < 0) begin
                    r[i] = COORD_MIN;
                    ov = 1'b1;
                end
            end else begin
                r[i] = clamp((r[i] <<< SCALE_FRAC) / sc[i], ov);
            end
        end
        res.x = r[0][31:0];
        res.y = r[1][31:0];
        res.z = r[2][31:0];
        res.zs = zs;
        res.ov = ov;
        return res;
    endfunction

    // Result side: random stalls, with stretches of none.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        point_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h user %b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== want.x) begin
                    $display("%0t: result_x expected %h actual %h", $time, want.x,
                             m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.y) begin
                    $display("%0t: result_y expected %h actual %h", $time, want.y,
                             m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== want.z) begin
                    $display("%0t: result_z expected %h actual %h", $time, want.z,
                             m_tdata[95:64]);
                    errors++;
                end
                if (m_tuser[0] !== want.zs) begin
                    $display("%0t: zero_scale expected %b actual %b", $time, want.zs,
                             m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== want.ov) begin
                    $display("%0t: overflowed expected %b actual %b", $time, want.ov,
                             m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Send one point word and record its expected result on acceptance.
    task automatic send_point(input logic func, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz);
        point_result_t want;
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {pz, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_point(func, {pz, py, px});
        pending_results.push_back(want);
        words_sent++;
        if (func == FUNC_INVERSE) inverse_words++;
        if (want.zs) zero_scale_seen++;
        if (want.ov) overflow_seen++;
    endtask

    // Wait until every expected result has been seen.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Register write through a setup and an access phase.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_QUAT:    quat_reg = value;
            REG_POS_X:   pos_reg[0] = value[31:0];
            REG_POS_Y:   pos_reg[1] = value[31:0];
            REG_POS_Z:   pos_reg[2] = value[31:0];
            REG_SCALE_X: scale_reg[0] = value[15:0];
            REG_SCALE_Y: scale_reg[1] = value[15:0];
            REG_SCALE_Z: scale_reg[2] = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [63:0] quat, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz,
                           input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] sz);
        drain();
        write_reg(REG_QUAT, quat);
        write_reg(REG_POS_X, {32'd0, px});
        write_reg(REG_POS_Y, {32'd0, py});
        write_reg(REG_POS_Z, {32'd0, pz});
        write_reg(REG_SCALE_X, {48'd0, sx});
        write_reg(REG_SCALE_Y, {48'd0, sy});
        write_reg(REG_SCALE_Z, {48'd0, sz});
    endtask

    // Reset settings: identity, with coordinate extremes in both directions.
    task automatic test_identity_extremes;
        send_point(FUNC_FORWARD, 32'd0, 32'd0, 32'd0);
        send_point(FUNC_FORWARD, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send_point(FUNC_FORWARD, 32'h80000000, 32'h7FFFFFFF, 32'h00000001);
        send_point(FUNC_INVERSE, 32'h7FFFFFFF, 32'h80000000, 32'h00010000);
        send_point(FUNC_INVERSE, 32'hFFFF0000, 32'h00000000, 32'h80000000);
    endtask

    // Quarter turns about z and then about x with extreme scales and positions.
    task automatic test_rotation_scale;
        set_all({16'd0, 16'd0, 16'd11585, 16'd11585}, 32'h7FFFFFFF, 32'h80000000,
                32'h00018000, 16'h7FFF, 16'h8000, 16'h0180);
        send_point(FUNC_FORWARD, 32'h00010000, 32'h00020000, 32'h00030000);
        send_point(FUNC_FORWARD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_point(FUNC_INVERSE, 32'h00010000, 32'hFFFE0000, 32'h00030000);
        send_point(FUNC_INVERSE, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        set_all({16'd11585, 16'd0, 16'd0, 16'd11585}, 32'h00000100, 32'hFFFFFF00,
                32'h0, 16'h0001, 16'hFFFF, 16'h0100);
        send_point(FUNC_FORWARD, 32'h00050000, 32'hFFFB0000, 32'h00001234);
        send_point(FUNC_INVERSE, 32'h00050000, 32'hFFFB0000, 32'h00001234);
    endtask

    // Zero scales: forward zeroes the axis, inverse flags and saturates by sign.
    task automatic test_zero_scale;
        set_all(QUAT_RESET, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        send_point(FUNC_INVERSE, 32'h00010000, 32'hFFFF0000, 32'h0);
        send_point(FUNC_INVERSE, 32'h0, 32'h0, 32'h0);
        send_point(FUNC_FORWARD, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
    endtask

    // Non-unit quaternions that push intermediates into saturation.
    task automatic test_non_unit_quat;
        set_all({4{16'h7FFF}}, 32'h0, 32'h0, 32'h0, SCALE_RESET, SCALE_RESET, SCALE_RESET);
        send_point(FUNC_FORWARD, 32'h40000000, 32'hC0000000, 32'h20000000);
        send_point(FUNC_INVERSE, 32'h00010000, 32'h00020000, 32'hFFFD0000);
        set_all({4{16'h8000}}, 32'h80000000, 32'h7FFFFFFF, 32'h0, 16'h7FFF, 16'h8000,
                16'h0001);
        send_point(FUNC_FORWARD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_point(FUNC_INVERSE, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
    endtask

    function automatic logic [31:0] rand_coord;
        if ($urandom_range(0, 3) != 0) return 32'($signed($urandom_range(0, 32'h1FFFFF)) -
                                                 32'sh100000);
        return $urandom;
    endfunction

    function automatic logic [15:0] rand_scale;
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return SCALE_RESET;
            default: return 16'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    function automatic logic [63:0] rand_quat;
        case ($urandom_range(0, 4))
            0: return QUAT_RESET;
            1: return {16'd0, 16'd11585, 16'd0, 16'd11585};
            2: return {16'd8192, 16'hE000, 16'd8192, 16'd8192};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random settings per phase, random points, gaps on and off.
    task automatic test_random_stream;
        for (int phase = 0; phase < 5; phase++) begin
            set_all(rand_quat(), rand_coord(), rand_coord(), rand_coord(),
                    rand_scale(), rand_scale(), rand_scale());
            gaps_on = (phase != 2);
            for (int n = 0; n < 100; n++) begin
                if (phase == 3 && n == 50) drain();
                send_point(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                           rand_coord());
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity_extremes();
        test_rotation_scale();
        test_zero_scale();
        test_non_unit_quat();
        test_random_stream();
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("Sent %0d points (%0d inverse), checked %0d results.", words_sent,
                 inverse_words, words_checked);
        $display("Expected flags: %0d zero-scale, %0d saturated; %0d mismatches.",
                 zero_scale_seen, overflow_seen, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/srt_pkg.sv
rtl/core/srt_prep.sv
rtl/core/srt_rotate.sv
rtl/core/srt_divide.sv
rtl/core/scaled_rigid_transform_point_unit.sv
tb/scaled_rigid_transform_point_unit_tb.sv
